FILE: rtl/usb_config_descriptor_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the descriptor parser checker
// Implication forms clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_CORE_MACROS_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define UCDP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UCDP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ucdp_pkg.sv
// ----------------------------------------------------------------------------
// ucdp_pkg
// Types, descriptor codes and commit helpers for the descriptor parser.
// ----------------------------------------------------------------------------
package ucdp_pkg;

  localparam logic [7:0] DT_INTERFACE = 8'h04;
  localparam logic [7:0] DT_ENDPOINT  = 8'h05;
  localparam logic [7:0] DT_HID       = 8'h21;
  localparam logic [7:0] DT_SS_COMP   = 8'h30;
  localparam logic [7:0] CLASS_HID    = 8'h03;
  localparam logic [7:0] CLASS_MSC    = 8'h08;
  localparam logic [7:0] SUB_SCSI     = 8'h06;
  localparam logic [7:0] PROTO_BOT    = 8'h50;
  localparam logic [7:0] SUB_BOOT     = 8'h01;
  localparam logic [7:0] PROTO_KBD    = 8'h01;
  localparam logic [1:0] XFER_BULK    = 2'd2;
  localparam logic [1:0] XFER_INT     = 2'd3;
  localparam logic [3:0] MIN_BYTES    = 4'd9;

  localparam logic [1:0] KIND_KBD      = 2'd0;
  localparam logic [1:0] KIND_MOUSE    = 2'd1;
  localparam logic [1:0] KIND_BULK_IN  = 2'd2;
  localparam logic [1:0] KIND_BULK_OUT = 2'd3;

  typedef enum logic [1:0] {EK_NONE, EK_HID, EK_BIN, EK_BOUT} ep_kind_t;

  typedef struct packed {
    logic        present;
    logic        has_ep;
    logic        boot;
    logic        is_kbd;
    logic [7:0]  iface;
    logic [7:0]  alt;
    logic [4:0]  ep;
    logic [7:0]  interval;
    logic [7:0]  burst;
    logic [1:0]  mult;
    logic [10:0] mps;
    logic [15:0] rlen;
    logic [15:0] esit;
  } hid_cand_t;

  typedef struct packed {
    logic        present;
    logic        has_in;
    logic        has_out;
    logic [7:0]  iface;
    logic [7:0]  alt;
    logic [4:0]  ep_in;
    logic [4:0]  ep_out;
    logic [7:0]  burst_in;
    logic [7:0]  burst_out;
    logic [10:0] mps_in;
    logic [10:0] mps_out;
  } stor_cand_t;

  typedef struct packed {
    logic        found;
    logic        boot;
    logic [7:0]  iface;
    logic [7:0]  alt;
    logic [4:0]  ep;
    logic [4:0]  ep_out;
    logic [7:0]  burst;
    logic [7:0]  burst_out;
    logic [1:0]  mult;
    logic [7:0]  interval;
    logic [10:0] mps;
    logic [10:0] mps_out;
    logic [15:0] esit;
    logic [15:0] rlen;
  } rec_t;

  typedef rec_t [2:0] recs_t;

  typedef struct packed {
    logic [1:0]  func_kind;
    logic        last_result;
    logic [7:0]  iface_num;
    logic [7:0]  alt_num;
    logic [4:0]  endpoint_index;
    logic [10:0] pkt_size;
    logic [7:0]  burst_size;
    logic [1:0]  mult;
    logic [15:0] esit_payload;
    logic [7:0]  poll_interval;
    logic [15:0] report_length;
    logic        boot_class;
  } res_t;

  typedef struct packed {
    logic           load;
    res_t [3:0]     res;
  } fin_t;

  function automatic logic may_replace(rec_t r, logic [7:0] iface, logic [7:0] alt);
    return !r.found || (iface == r.iface && alt == 8'd0 && r.alt != 8'd0);
  endfunction

  function automatic recs_t commit_all(hid_cand_t h, stor_cand_t s, recs_t r);
    recs_t o;
    rec_t  n;
    o = r;
    n = '0;
    n.found = 1'b1;
    n.iface = h.iface;
    n.alt = h.alt;
    n.ep = h.ep;
    n.mps = h.mps;
    n.interval = h.interval;
    n.rlen = h.rlen;
    n.burst = h.burst;
    n.mult = h.mult;
    n.esit = h.esit;
    n.boot = h.boot;
    if (h.present && h.has_ep) begin
      if (h.is_kbd) begin
        if (may_replace(o[0], h.iface, h.alt)) o[0] = n;
      end else begin
        if (may_replace(o[1], h.iface, h.alt)) o[1] = n;
      end
    end
    n = '0;
    n.found = 1'b1;
    n.iface = s.iface;
    n.alt = s.alt;
    n.ep = s.ep_in;
    n.ep_out = s.ep_out;
    n.mps = s.mps_in;
    n.mps_out = s.mps_out;
    n.burst = s.burst_in;
    n.burst_out = s.burst_out;
    if (s.present && s.has_in && s.has_out && may_replace(o[2], s.iface, s.alt)) o[2] = n;
    return o;
  endfunction

  function automatic res_t put_result(logic [1:0] kind, rec_t r);
    res_t o;
    logic hid;
    logic sout;
    hid = (kind == KIND_KBD) || (kind == KIND_MOUSE);
    sout = (kind == KIND_BULK_OUT);
    o = '0;
    o.func_kind = kind;
    o.last_result = sout;
    if (r.found) begin
      o.iface_num = r.iface;
      o.alt_num = r.alt;
      o.endpoint_index = sout ? r.ep_out : r.ep;
      o.pkt_size = sout ? r.mps_out : r.mps;
      o.burst_size = sout ? r.burst_out : r.burst;
      if (hid) begin
        o.mult = r.mult;
        o.esit_payload = r.esit;
        o.poll_interval = r.interval;
        o.report_length = r.rlen;
        o.boot_class = r.boot;
      end
    end
    return o;
  endfunction

endpackage

FILE: rtl/ucdp_desc_if.sv
// ----------------------------------------------------------------------------
// ucdp_desc_if
// Valid/ready channel for descriptor bytes.
// ----------------------------------------------------------------------------
interface ucdp_desc_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

FILE: rtl/ucdp_func_if.sv
// ----------------------------------------------------------------------------
// ucdp_func_if
// Valid/ready channel carrying one function record per request.
// ----------------------------------------------------------------------------
interface ucdp_func_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func_kind;
  logic        last_result;
  logic [7:0]  iface_num;
  logic [7:0]  alt_num;
  logic [4:0]  endpoint_index;
  logic [10:0] pkt_size;
  logic [7:0]  burst_size;
  logic [1:0]  mult;
  logic [15:0] esit_payload;
  logic [7:0]  poll_interval;
  logic [15:0] report_length;
  logic        boot_class;
  modport source(output valid, func_kind, last_result, iface_num, alt_num,
                 endpoint_index, pkt_size, burst_size, mult, esit_payload,
                 poll_interval, report_length, boot_class, input ready);
  modport sink(input valid, func_kind, last_result, iface_num, alt_num,
               endpoint_index, pkt_size, burst_size, mult, esit_payload,
               poll_interval, report_length, boot_class, output ready);
endinterface

FILE: rtl/ucdp_parser.sv
// ----------------------------------------------------------------------------
// ucdp_parser
// Record walker, candidate tracking and commit; builds the four results.
// ----------------------------------------------------------------------------
module ucdp_parser (
  input  logic               clk,
  input  logic               rst,
  ucdp_desc_if.sink          desc,
  input  logic               out_busy,
  output ucdp_pkg::fin_t     fin
);

  logic [3:0]            cnt, cnt_next;
  logic [7:0]            pos, pos_next;
  logic [7:0]            len, len_next;
  logic [8:0][7:0]       rb, rb_next;
  logic                  stopped, stopped_next;
  ucdp_pkg::ep_kind_t    lek, lek_next;
  ucdp_pkg::hid_cand_t   hc, hc_next;
  ucdp_pkg::stor_cand_t  sc, sc_next;
  ucdp_pkg::recs_t       recs, recs_next;
  logic                  fin_pend, fin_pend_next;

  logic                  fire;
  logic [8:0][7:0]       b;
  logic [10:0]           mps;
  logic                  dir_in;
  ucdp_pkg::recs_t       r;

  assign desc.ready = !fin_pend;
  assign fire = desc.valid && desc.ready;

  always_comb begin
    cnt_next = cnt;
    pos_next = pos;
    len_next = len;
    rb_next = rb;
    stopped_next = stopped;
    lek_next = lek;
    hc_next = hc;
    sc_next = sc;
    recs_next = recs;
    fin_pend_next = fin_pend;
    fin = '0;
    b = rb;
    mps = {b[5][2:0], b[4]};
    dir_in = b[2][7];
    r = '0;
    if (fire) begin
      if (cnt != ucdp_pkg::MIN_BYTES) cnt_next = cnt + 4'd1;
      if (!stopped) begin
        if (pos == 8'd0) begin
          if (desc.data_byte < 8'd2) begin
            stopped_next = 1'b1;
          end else begin
            rb_next = '0;
            rb_next[0] = desc.data_byte;
            len_next = desc.data_byte;
            pos_next = 8'd1;
          end
        end else begin
          if (pos < 8'd9) b[pos[3:0]] = desc.data_byte;
          mps = {b[5][2:0], b[4]};
          dir_in = b[2][7];
          rb_next = b;
          pos_next = pos + 8'd1;
          if (pos + 8'd1 == len) begin
            pos_next = 8'd0;
            if (b[1] == ucdp_pkg::DT_INTERFACE && len >= 8'd9) begin
              recs_next = ucdp_pkg::commit_all(hc, sc, recs);
              hc_next = '0;
              sc_next = '0;
              lek_next = ucdp_pkg::EK_NONE;
              if (b[5] == ucdp_pkg::CLASS_HID) begin
                hc_next.present = 1'b1;
                hc_next.iface = b[2];
                hc_next.alt = b[3];
                hc_next.boot = (b[6] == ucdp_pkg::SUB_BOOT);
                hc_next.is_kbd = (b[7] == ucdp_pkg::PROTO_KBD);
              end else if (b[5] == ucdp_pkg::CLASS_MSC && b[6] == ucdp_pkg::SUB_SCSI &&
                           b[7] == ucdp_pkg::PROTO_BOT) begin
                sc_next.present = 1'b1;
                sc_next.iface = b[2];
                sc_next.alt = b[3];
              end
            end else if (b[1] == ucdp_pkg::DT_HID && hc.present && len >= 8'd9) begin
              hc_next.rlen = {b[8], b[7]};
            end else if (b[1] == ucdp_pkg::DT_ENDPOINT && len >= 8'd7) begin
              lek_next = ucdp_pkg::EK_NONE;
              if (hc.present && dir_in && b[3][1:0] == ucdp_pkg::XFER_INT && !hc.has_ep) begin
                hc_next.ep = {b[2][3:0], 1'b1};
                hc_next.mps = mps;
                hc_next.interval = b[6];
                hc_next.has_ep = 1'b1;
                hc_next.burst = 8'd0;
                hc_next.mult = 2'd0;
                hc_next.esit = {5'd0, mps};
                lek_next = ucdp_pkg::EK_HID;
              end else if (sc.present && b[3][1:0] == ucdp_pkg::XFER_BULK) begin
                if (dir_in && !sc.has_in) begin
                  sc_next.ep_in = {b[2][3:0], 1'b1};
                  sc_next.mps_in = mps;
                  sc_next.has_in = 1'b1;
                  lek_next = ucdp_pkg::EK_BIN;
                end else if (!dir_in && !sc.has_out) begin
                  sc_next.ep_out = {b[2][3:0], 1'b0};
                  sc_next.mps_out = mps;
                  sc_next.has_out = 1'b1;
                  lek_next = ucdp_pkg::EK_BOUT;
                end
              end
            end else if (b[1] == ucdp_pkg::DT_SS_COMP && hc.present &&
                         lek == ucdp_pkg::EK_HID && hc.has_ep && len >= 8'd6) begin
              hc_next.burst = b[2];
              hc_next.mult = b[3][1:0];
              hc_next.esit = {b[5], b[4]};
            end else if (b[1] == ucdp_pkg::DT_SS_COMP && sc.present && len >= 8'd6) begin
              if (lek == ucdp_pkg::EK_BIN) sc_next.burst_in = b[2];
              else if (lek == ucdp_pkg::EK_BOUT) sc_next.burst_out = b[2];
            end
          end
        end
      end
      if (desc.last_byte) fin_pend_next = 1'b1;
    end
    if (fin_pend && !out_busy) begin
      if (cnt >= ucdp_pkg::MIN_BYTES) r = ucdp_pkg::commit_all(hc, sc, recs);
      fin.load = 1'b1;
      fin.res[0] = ucdp_pkg::put_result(ucdp_pkg::KIND_KBD, r[0]);
      fin.res[1] = ucdp_pkg::put_result(ucdp_pkg::KIND_MOUSE, r[1]);
      fin.res[2] = ucdp_pkg::put_result(ucdp_pkg::KIND_BULK_IN, r[2]);
      fin.res[3] = ucdp_pkg::put_result(ucdp_pkg::KIND_BULK_OUT, r[2]);
      cnt_next = '0;
      pos_next = '0;
      len_next = '0;
      rb_next = '0;
      stopped_next = 1'b0;
      lek_next = ucdp_pkg::EK_NONE;
      hc_next = '0;
      sc_next = '0;
      recs_next = '0;
      fin_pend_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pos <= '0;
      len <= '0;
      rb <= '0;
      stopped <= 1'b0;
      lek <= ucdp_pkg::EK_NONE;
      hc <= '0;
      sc <= '0;
      recs <= '0;
      fin_pend <= 1'b0;
    end else begin
      cnt <= cnt_next;
      pos <= pos_next;
      len <= len_next;
      rb <= rb_next;
      stopped <= stopped_next;
      lek <= lek_next;
      hc <= hc_next;
      sc <= sc_next;
      recs <= recs_next;
      fin_pend <= fin_pend_next;
    end
  end

endmodule

FILE: rtl/ucdp_out_buf.sv
// ----------------------------------------------------------------------------
// ucdp_out_buf
// Holds the four function records and hands them out in order.
// ----------------------------------------------------------------------------
module ucdp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  ucdp_pkg::fin_t    fin,
  output logic              busy,
  ucdp_func_if.source       func
);

  ucdp_pkg::res_t [3:0] held;
  logic [1:0]           idx;
  ucdp_pkg::res_t       cur;

  assign cur = held[idx];
  assign func.valid = busy;
  assign func.func_kind = cur.func_kind;
  assign func.last_result = cur.last_result;
  assign func.iface_num = cur.iface_num;
  assign func.alt_num = cur.alt_num;
  assign func.endpoint_index = cur.endpoint_index;
  assign func.pkt_size = cur.pkt_size;
  assign func.burst_size = cur.burst_size;
  assign func.mult = cur.mult;
  assign func.esit_payload = cur.esit_payload;
  assign func.poll_interval = cur.poll_interval;
  assign func.report_length = cur.report_length;
  assign func.boot_class = cur.boot_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (fin.load) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (busy && func.ready) begin
      if (idx == 2'd3) busy <= 1'b0;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.load) held <= fin.res;
  end

endmodule

FILE: rtl/usb_config_descriptor_parser_core.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser_core
// Walks a configuration descriptor set and reports keyboard, mouse and
// storage bulk endpoints as four records per run.
// ----------------------------------------------------------------------------
//  channel | dir | request
//  desc    | in  | one descriptor byte, last_byte marks the end of the set
//  func    | out | one function record, four per set
//
//  A byte is taken every cycle that ready is high; its record fields are parsed
//  in the same cycle it is taken. After the last byte, ready drops while the
//  four records are committed, and stays low while the previous four still wait.
//  The records then leave one per cycle that func.ready is high.
//  Synchronous reset clears all parse state and the output queue.
module usb_config_descriptor_parser_core (
  input  logic        clk,
  input  logic        rst,
  ucdp_desc_if.sink   desc,
  ucdp_func_if.source func
);

  ucdp_pkg::fin_t fin;
  logic           busy;

  ucdp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .desc     (desc),
    .out_busy (busy),
    .fin      (fin)
  );

  ucdp_out_buf u_out (
    .clk  (clk),
    .rst  (rst),
    .fin  (fin),
    .busy (busy),
    .func (func)
  );

endmodule

FILE: rtl/ucdp_checker.sv
// ----------------------------------------------------------------------------
// ucdp_checker
// Port-level checks on the function record stream.
// ----------------------------------------------------------------------------
`include "usb_config_descriptor_parser_core_macros.svh"

module ucdp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic        last,
  input logic [7:0]  iface,
  input logic [4:0]  ep,
  input logic [10:0] mps,
  input logic [1:0]  mult,
  input logic [15:0] esit,
  input logic [7:0]  poll,
  input logic [15:0] rlen,
  input logic        boot
);

  logic fire;
  assign fire = out_valid && out_ready;

  `UCDP_ASSERT_IMP(a_last_kind, out_valid, last == (kind == ucdp_pkg::KIND_BULK_OUT), "last flag mismatch")
  `UCDP_ASSERT_NXT(a_run_cont, fire && !last, out_valid && kind == $past(kind) + 2'd1, "record run broken")
  `UCDP_ASSERT_IMP(a_stor_zero, out_valid && kind[1], mult == 2'd0 && esit == 16'd0 && poll == 8'd0 && rlen == 16'd0 && !boot, "storage HID fields set")
  `UCDP_ASSERT_IMP(a_hid_absent, out_valid && !kind[1] && ep == 5'd0, iface == 8'd0 && mps == 11'd0 && esit == 16'd0, "absent HID not zero")

endmodule

bind usb_config_descriptor_parser_core ucdp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (func.valid),
  .out_ready (func.ready),
  .kind      (func.func_kind),
  .last      (func.last_result),
  .iface     (func.iface_num),
  .ep        (func.endpoint_index),
  .mps       (func.pkt_size),
  .mult      (func.mult),
  .esit      (func.esit_payload),
  .poll      (func.poll_interval),
  .rlen      (func.report_length),
  .boot      (func.boot_class)
);
